// ----- sv/k2rgb_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and fixed-point helpers for the kelvin to RGB pipeline.
// No dependencies; every other file imports this package.
package k2rgb_pkg;

  localparam int QF                = 48;
  localparam int OUT_FRAC_BITS_DEF = 8;
  localparam int LOG_LAT           = 97;
  localparam int POW_LAT           = 104;
  localparam int FIT_LAT           = 5;
  localparam int TERMS             = 24;
  localparam int LINE_LEN          = LOG_LAT + POW_LAT;
  localparam int TOTAL_LAT         = LINE_LEN + 2;

  localparam logic [15:0] K_MIN  = 16'd1000;
  localparam logic [15:0] K_MAX  = 16'd40000;
  localparam logic [15:0] K_KNEE = 16'd6600;
  localparam logic [15:0] K_DARK = 16'd1900;
  localparam logic [15:0] K_OFS1 = 16'd6000;
  localparam logic [15:0] K_OFS2 = 16'd1000;

  localparam logic [63:0] DEC_SCALE = 64'd10000000000;

  typedef struct packed {
    logic [63:0] p11;
    logic [63:0] p10;
    logic [63:0] p01;
    logic [63:0] p00;
  } pp_t;

  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  // four 32 x 32 partial products of a 64 x 64 product
  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t pp;
    pp.p00 = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    pp.p01 = {32'd0, a[31:0]} * {32'd0, b[63:32]};
    pp.p10 = {32'd0, a[63:32]} * {32'd0, b[31:0]};
    pp.p11 = {32'd0, a[63:32]} * {32'd0, b[63:32]};
    return pp;
  endfunction

  // add the partial products and keep 64 bits of the product shifted right by s
  function automatic logic [63:0] pp_shr(input pp_t pp, input int s);
    logic [127:0] acc;
    acc = {pp.p11, pp.p00} + {32'd0, pp.p10, 32'd0} + {32'd0, pp.p01, 32'd0};
    return 64'(acc >> s);
  endfunction

  function automatic logic [63:0] dec_q(input logic [63:0] ip, input logic [63:0] frac,
                                        input int q);
    logic [63:0] r;
    logic [63:0] rem;
    r   = ip << q;
    rem = frac;
    for (int i = 0; i < q; i++) begin
      rem = rem << 1;
      if (rem >= DEC_SCALE) begin
        rem = rem - DEC_SCALE;
        r   = r | (64'd1 << (q - 1 - i));
      end
    end
    if ((rem << 1) >= DEC_SCALE) r = r + 64'd1;
    return r;
  endfunction

  function automatic logic [63:0] log2_q48(input logic [31:0] n);
    int          p;
    logic [63:0] m;
    logic [63:0] r;
    p = 0;
    for (int j = 0; j < 31; j++) begin
      if ((n >> (j + 1)) != 32'd0) p = j + 1;
    end
    m = 64'(n) << (62 - p);
    r = 64'(p) << QF;
    for (int k = QF; k > 0; k--) begin
      m = mul_shr(m, m, 62);
      if (m[63]) begin
        m = m >> 1;
        r = r | (64'd1 << (k - 1));
      end
    end
    return r;
  endfunction

  localparam logic [63:0] LN2_60 = dec_q(64'd0, 64'd6931471806, 60);
  localparam logic [63:0] LOG100 = log2_q48(32'd100);
  localparam logic [63:0] FULL   = 64'd255 << QF;
  localparam logic [63:0] C_RED  = dec_q(64'd329, 64'd6987274460, QF);
  localparam logic [63:0] E_RED  = dec_q(64'd0, 64'd1332047592, QF);
  localparam logic [63:0] C_GRN  = dec_q(64'd288, 64'd1221695283, QF);
  localparam logic [63:0] E_GRN  = dec_q(64'd0, 64'd755148492, QF);
  localparam logic [63:0] A_GRN  = dec_q(64'd99, 64'd4708025861, QF);
  localparam logic [63:0] B_GRN  = dec_q(64'd161, 64'd1195681661, QF);
  localparam logic [63:0] A_BLU  = dec_q(64'd138, 64'd5177312231, QF);
  localparam logic [63:0] B_BLU  = dec_q(64'd305, 64'd447927307, QF);

endpackage

// ----- sv/k2rgb_log2.sv -----
`timescale 1ns / 1ps
// Pipelined log2 of a 16-bit integer in Q48: normalise, then one squaring per stage (registers pp_r and m_r).
// Depends on k2rgb_pkg.
module k2rgb_log2 (
  input  logic        clk,
  input  logic [15:0] n,
  output logic [63:0] lg
);
  import k2rgb_pkg::*;

  logic [63:0] m_r  [0:QF];
  logic [63:0] r_r  [0:QF];
  pp_t         pp_r [1:QF];
  logic [63:0] rp_r [1:QF];
  logic [3:0]  p;

  always_comb begin
    p = 4'd0;
    for (int j = 1; j < 16; j++) begin
      if (n[j]) p = 4'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (n == 16'd0) begin
      m_r[0] <= 64'd1 << 62;
      r_r[0] <= 64'd0;
    end else begin
      m_r[0] <= {48'd0, n} << (7'd62 - {3'd0, p});
      r_r[0] <= {60'd0, p} << QF;
    end
  end

  for (genvar k = 1; k <= QF; k++) begin : g_sq
    logic [63:0] sq;
    assign sq = pp_shr(pp_r[k], 62);
    always_ff @(posedge clk) begin
      pp_r[k] <= mul_pp(m_r[k-1], m_r[k-1]);
      rp_r[k] <= r_r[k-1];
      if (sq[63]) begin
        m_r[k] <= sq >> 1;
        r_r[k] <= rp_r[k] | (64'd1 << (QF - k));
      end else begin
        m_r[k] <= sq;
        r_r[k] <= rp_r[k];
      end
    end
  end

  assign lg = r_r[QF];

endmodule

// ----- sv/k2rgb_pow.sv -----
`timescale 1ns / 1ps
// Pipelined C * t^(-E) from log2 t, via 2^frac as a Taylor series, one term per
// stage (registers pa_r, p_r, pb_r and sum_r). Depends on k2rgb_pkg.
module k2rgb_pow #(
  parameter logic [63:0] C = 64'd0,
  parameter logic [63:0] E = 64'd0
) (
  input  logic        clk,
  input  logic [63:0] lt,
  output logic [63:0] val
);
  import k2rgb_pkg::*;

  localparam logic [63:0] ONE48 = 64'd1 << QF;

  pp_t         ypp_r;
  logic [63:0] y_r;
  logic [63:0] g_r;
  logic [7:0]  ib_r;
  pp_t         zpp_r;
  logic [7:0]  iz_r;
  logic [63:0] z_r    [0:TERMS-1];
  logic [63:0] term_r [0:TERMS-1];
  logic [63:0] sum_r  [0:TERMS];
  logic [7:0]  i_r    [0:TERMS];
  logic [63:0] r_r;
  pp_t         cpp_r;
  logic [63:0] val_r;
  logic [47:0] f;
  logic [63:0] g;
  logic [7:0]  ib;

  always_comb begin
    f  = y_r[47:0];
    ib = 8'(y_r >> QF);
    g  = 64'd0;
    if (f != 48'd0) begin
      g  = ONE48 - {16'd0, f};
      ib = ib + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    ypp_r     <= mul_pp(E, lt);
    y_r       <= pp_shr(ypp_r, QF);
    g_r       <= g;
    ib_r      <= ib;
    zpp_r     <= mul_pp(g_r, LN2_60);
    iz_r      <= ib_r;
    z_r[0]    <= pp_shr(zpp_r, QF);
    term_r[0] <= 64'd1 << 60;
    sum_r[0]  <= 64'd1 << 60;
    i_r[0]    <= iz_r;
  end

  // term / k as a reciprocal multiply, exact for the products below 2^60 seen here
  for (genvar k = 1; k <= TERMS; k++) begin : g_term
    localparam int           DSH = (k <= 2) ? 62 + k : 65;
    localparam logic [127:0] NUM = 128'd1 << DSH;
    localparam logic [63:0]  RCP = 64'((NUM + 128'(k) - 128'd1) / 128'(k));
    pp_t         pa_r;
    pp_t         pb_r;
    logic [63:0] p_r;
    logic [63:0] q;
    logic [63:0] sd_r [0:2];
    logic [7:0]  id_r [0:2];
    assign q = pp_shr(pb_r, DSH);
    always_ff @(posedge clk) begin
      pa_r     <= mul_pp(term_r[k-1], z_r[k-1]);
      p_r      <= pp_shr(pa_r, 60);
      pb_r     <= mul_pp(p_r, RCP);
      sd_r[0]  <= sum_r[k-1];
      sd_r[1]  <= sd_r[0];
      sd_r[2]  <= sd_r[1];
      id_r[0]  <= i_r[k-1];
      id_r[1]  <= id_r[0];
      id_r[2]  <= id_r[1];
      sum_r[k] <= sd_r[2] + q;
      i_r[k]   <= id_r[2];
    end
    if (k < TERMS) begin : g_pass
      logic [63:0] zd_r [0:2];
      always_ff @(posedge clk) begin
        zd_r[0]   <= z_r[k-1];
        zd_r[1]   <= zd_r[0];
        zd_r[2]   <= zd_r[1];
        z_r[k]    <= zd_r[2];
        term_r[k] <= q;
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= (i_r[TERMS] < 8'd64) ? (sum_r[TERMS] >> i_r[TERMS][5:0]) : 64'd0;
    cpp_r <= mul_pp(C, r_r);
    val_r <= pp_shr(cpp_r, 60);
  end

  assign val = val_r;

endmodule

// ----- sv/kelvin_to_rgb_unit.sv -----
`timescale 1ns / 1ps
// Kelvin to RGB: out_valid rises once an item has passed the whole line below; one item per cycle.
// Depth: one input register, log2 (a normalise register, then 48 squaring stages), power
// (24 series stages), one output register. busy is always low.
// Reset (rst_n, synchronous, active low) clears the valid line; payload is not reset.
// Depends on k2rgb_pkg, k2rgb_log2, k2rgb_pow.
module kelvin_to_rgb_unit #(
  parameter int OUT_FRAC_BITS = k2rgb_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_kelvin,
  output logic        out_valid,
  output logic [15:0] out_red_level,
  output logic [15:0] out_green_level,
  output logic [15:0] out_blue_level
);
  import k2rgb_pkg::*;

  localparam int SH = QF - OUT_FRAC_BITS;

  typedef struct packed {
    logic valid;
    logic lo;
    logic hi;
    logic dark;
  } ctl_t;

  function automatic logic [15:0] to_level(input logic [63:0] v);
    logic [63:0] c;
    logic [63:0] r;
    c = (v > FULL) ? FULL : v;
    r = (c + (64'd1 << (SH - 1))) >> SH;
    return (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
  endfunction

  logic        vin_r;
  logic [15:0] x_r;
  logic [15:0] xc;
  logic [15:0] n1;
  logic [15:0] n2;
  ctl_t        ctl_in;
  ctl_t        ctl_r [0:LINE_LEN-1];
  logic [63:0] lg1;
  logic [63:0] lg2;
  logic [63:0] lt1;
  logic [63:0] lt2;
  logic [63:0] red_p;
  logic [63:0] grn_p;
  pp_t         glpp_r;
  logic [63:0] gln_r;
  pp_t         gvpp_r;
  logic [63:0] gv_r;
  logic [63:0] gf_r [0:POW_LAT-FIT_LAT];
  pp_t         blpp_r;
  logic [63:0] bln_r;
  pp_t         bvpp_r;
  logic [63:0] bv_r;
  logic [63:0] bf_r [0:POW_LAT-FIT_LAT];
  logic        out_valid_r;
  logic [15:0] red_r;
  logic [15:0] grn_r;
  logic [15:0] blu_r;
  logic [63:0] red_v;
  logic [63:0] grn_v;
  logic [63:0] blu_v;

  assign busy = 1'b0;

  always_comb begin
    xc = in_kelvin;
    if (xc < K_MIN) xc = K_MIN;
    if (xc > K_MAX) xc = K_MAX;
  end

  always_ff @(posedge clk) begin
    x_r <= xc;
    if (!rst_n) begin
      vin_r <= 1'b0;
    end else begin
      vin_r <= start && !busy;
    end
  end

  assign n1 = (x_r <= K_KNEE) ? x_r : (x_r - K_OFS1);
  assign n2 = x_r - K_OFS2;

  assign ctl_in = '{valid: vin_r, lo: (x_r <= K_KNEE), hi: (x_r >= K_KNEE),
                    dark: (x_r <= K_DARK)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINE_LEN; i++) ctl_r[i] <= '0;
    end else begin
      ctl_r[0] <= ctl_in;
      for (int i = 1; i < LINE_LEN; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  k2rgb_log2 u_log1 (.clk(clk), .n(n1), .lg(lg1));
  k2rgb_log2 u_log2 (.clk(clk), .n(n2), .lg(lg2));

  assign lt1 = lg1 - LOG100;
  assign lt2 = lg2 - LOG100;

  k2rgb_pow #(.C(C_RED), .E(E_RED)) u_pow_red (.clk(clk), .lt(lt1), .val(red_p));
  k2rgb_pow #(.C(C_GRN), .E(E_GRN)) u_pow_grn (.clk(clk), .lt(lt1), .val(grn_p));

  always_ff @(posedge clk) begin
    glpp_r   <= mul_pp(lt1, LN2_60);
    gln_r    <= pp_shr(glpp_r, 60);
    gvpp_r   <= mul_pp(A_GRN, gln_r);
    gv_r     <= pp_shr(gvpp_r, QF);
    gf_r[0]  <= (gv_r > B_GRN) ? (gv_r - B_GRN) : 64'd0;
    blpp_r   <= mul_pp(lt2, LN2_60);
    bln_r    <= pp_shr(blpp_r, 60);
    bvpp_r   <= mul_pp(A_BLU, bln_r);
    bv_r     <= pp_shr(bvpp_r, QF);
    bf_r[0]  <= (bv_r > B_BLU) ? (bv_r - B_BLU) : 64'd0;
    for (int i = 1; i <= POW_LAT - FIT_LAT; i++) begin
      gf_r[i] <= gf_r[i-1];
      bf_r[i] <= bf_r[i-1];
    end
  end

  always_comb begin
    red_v = ctl_r[LINE_LEN-1].lo ? FULL : red_p;
    grn_v = ctl_r[LINE_LEN-1].lo ? gf_r[POW_LAT-FIT_LAT] : grn_p;
    if (ctl_r[LINE_LEN-1].hi) begin
      blu_v = FULL;
    end else if (ctl_r[LINE_LEN-1].dark) begin
      blu_v = 64'd0;
    end else begin
      blu_v = bf_r[POW_LAT-FIT_LAT];
    end
  end

  always_ff @(posedge clk) begin
    red_r <= to_level(red_v);
    grn_r <= to_level(grn_v);
    blu_r <= to_level(blu_v);
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_r[LINE_LEN-1].valid;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = red_r;
  assign out_green_level = grn_r;
  assign out_blue_level  = blu_r;

endmodule

// ----- sv/k2rgb_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for kelvin_to_rgb_unit, attached by bind.
// Depends on k2rgb_pkg.
module k2rgb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [15:0] out_red_level,
  input logic [15:0] out_green_level,
  input logic [15:0] out_blue_level
);
  import k2rgb_pkg::*;

  localparam logic [15:0] FULL_LVL = 16'd255 << OUT_FRAC_BITS_DEF;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, TOTAL_LAT))
    else $error("result without matching item");

  a_dark_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_blue_level == 16'd0) |-> out_red_level == FULL_LVL)
    else $error("no blue but red not full");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_green_level <= FULL_LVL) && (out_blue_level <= FULL_LVL))
    else $error("level above full scale");

endmodule

bind kelvin_to_rgb_unit k2rgb_checker u_k2rgb_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_red_level(out_red_level), .out_green_level(out_green_level),
  .out_blue_level(out_blue_level)
);
